@@ design/cdbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbr_pkg: shared types and codes of the cyclic dma buffer ring
// Field widths, operation and status codes, register indexes and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdbr_pkg;

   // fixed field widths
   localparam int ID_W      = 32;
   localparam int LEN_W     = 26;
   localparam int CNT_W     = 5;
   localparam int OFS_W     = 30;
   localparam int PROD_W    = 31;
   localparam int OP_W      = 3;
   localparam int RDR_W     = 3;
   localparam int ST_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // operations
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd0;
   localparam logic [OP_W-1:0] OP_ERROR    = 3'd1;
   localparam logic [OP_W-1:0] OP_OPEN     = 3'd2;
   localparam logic [OP_W-1:0] OP_READ     = 3'd3;
   localparam logic [OP_W-1:0] OP_CLOSE    = 3'd4;

   // read status codes
   localparam logic [ST_W-1:0] ST_DATA    = 2'd0;
   localparam logic [ST_W-1:0] ST_NOTHING = 2'd1;
   localparam logic [ST_W-1:0] ST_NONE    = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_BASE  = 2'd2;

   // register reset values and the slot count minimum
   localparam logic [CNT_W-1:0] COUNT_RESET = 5'd4;
   localparam logic [CNT_W-1:0] COUNT_MIN   = 5'd2;
   localparam logic [LEN_W-1:0] SIZE_RESET  = 26'd4096;

   // controller to datapath commands
   typedef struct packed {
      logic latch;
      logic arm_load;
      logic mod_start;
      logic mod_from_scan;
      logic slot_from_mod;
      logic arm_write;
      logic fin_write;
      logic arm_out;
      logic do_open;
      logic do_close;
      logic read_prep;
      logic set_nothing;
      logic set_none;
      logic scan_start;
      logic scan_next;
      logic scan_hit;
      logic respond;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            engine_on;
      logic            reader_ok;
      logic            reader_on;
      logic            ids_equal;
      logic            clen_nz;
      logic            mod_done;
      logic            scan_empty;
      logic            scan_last;
      logic            scan_match;
   } status_type;

endpackage

@@ design/cdbr_mod_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbr_mod_unit: id modulo slot count
// Restoring remainder of a 32-bit id by the slot count, two dividend bits per
// cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module cdbr_mod_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cdbr_pkg::ID_W-1:0]  dividend,
   input  logic [cdbr_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [cdbr_pkg::CNT_W-1:0] remainder
);

   localparam int STEPS  = cdbr_pkg::ID_W / 2;
   localparam int STEP_W = $clog2(STEPS);

   logic [cdbr_pkg::ID_W-1:0]  shift_ff;
   logic [cdbr_pkg::CNT_W-1:0] rem_ff;
   logic [cdbr_pkg::CNT_W-1:0] rem_half;
   logic [cdbr_pkg::CNT_W-1:0] rem_in;
   logic [STEP_W-1:0]          step_ff;
   logic                       run_ff;
   logic                       done_ff;

   // one restoring step: shift in a bit, subtract when it fits
   function automatic logic [cdbr_pkg::CNT_W-1:0] rem_step(
      input logic [cdbr_pkg::CNT_W-1:0] r,
      input logic                       b,
      input logic [cdbr_pkg::CNT_W-1:0] d
   );
      logic [cdbr_pkg::CNT_W:0] t;
      begin
         t = {r, b};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         return t[cdbr_pkg::CNT_W-1:0];
      end
   endfunction

   // two steps per cycle from the top of the dividend
   always_comb begin
      rem_half = rem_step(rem_ff, shift_ff[cdbr_pkg::ID_W-1], divisor);
      rem_in   = rem_step(rem_half, shift_ff[cdbr_pkg::ID_W-2], divisor);
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifter and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= dividend;
         rem_ff   <= '0;
      end else if (run_ff) begin
         shift_ff <= {shift_ff[cdbr_pkg::ID_W-3:0], 2'b00};
         rem_ff   <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ design/cdbr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbr_ctrl: event sequencer of the dma buffer ring
// Decodes each accepted event and walks the datapath through slot lookup,
// arming, completion bookkeeping and the reader scan.
// ----------------------------------------------------------------------------
module cdbr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cdbr_pkg::status_type sts,
   output cdbr_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DECODE     = 4'd1;
   localparam logic [3:0] S_MOD_WAIT   = 4'd2;
   localparam logic [3:0] S_ARM_WR     = 4'd3;
   localparam logic [3:0] S_FIN_WR     = 4'd4;
   localparam logic [3:0] S_ARM_OUT    = 4'd5;
   localparam logic [3:0] S_READ_START = 4'd6;
   localparam logic [3:0] S_SCAN_MODW  = 4'd7;
   localparam logic [3:0] S_SCAN_RD    = 4'd8;
   localparam logic [3:0] S_SCAN_CMP   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               cdbr_pkg::OP_COMPLETE, cdbr_pkg::OP_ERROR: begin
                  if (!sts.engine_on) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.arm_load  = 1'b1;
                     cmd.mod_start = 1'b1;
                     state_in      = S_MOD_WAIT;
                  end
               end
               cdbr_pkg::OP_OPEN: begin
                  if (!sts.reader_ok) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.do_open = 1'b1;
                     if (sts.engine_on) begin
                        cmd.respond = 1'b1;
                        state_in    = S_IDLE;
                     end else begin
                        cmd.arm_load  = 1'b1;
                        cmd.mod_start = 1'b1;
                        state_in      = S_MOD_WAIT;
                     end
                  end
               end
               cdbr_pkg::OP_READ: begin
                  if (!sts.reader_on) begin
                     cmd.set_none = 1'b1;
                     cmd.respond  = 1'b1;
                     state_in     = S_IDLE;
                  end else if (sts.ids_equal) begin
                     cmd.set_nothing = 1'b1;
                     cmd.respond     = 1'b1;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.read_prep = 1'b1;
                     state_in      = S_READ_START;
                  end
               end
               cdbr_pkg::OP_CLOSE: begin
                  cmd.do_close = 1'b1;
                  cmd.respond  = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_MOD_WAIT: begin
            if (sts.mod_done) begin
               cmd.slot_from_mod = 1'b1;
               state_in          = S_ARM_WR;
            end
         end
         S_ARM_WR: begin
            cmd.arm_write = 1'b1;
            if (sts.op == cdbr_pkg::OP_COMPLETE && sts.clen_nz) begin
               state_in = S_FIN_WR;
            end else begin
               state_in = S_ARM_OUT;
            end
         end
         S_FIN_WR: begin
            cmd.fin_write = 1'b1;
            state_in      = S_ARM_OUT;
         end
         S_ARM_OUT: begin
            cmd.arm_out = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_READ_START: begin
            if (sts.scan_empty) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_start    = 1'b1;
               cmd.mod_start     = 1'b1;
               cmd.mod_from_scan = 1'b1;
               state_in          = S_SCAN_MODW;
            end
         end
         S_SCAN_MODW: begin
            if (sts.mod_done) begin
               cmd.slot_from_mod = 1'b1;
               state_in          = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sts.scan_match) begin
               cmd.scan_hit = 1'b1;
               cmd.respond  = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.scan_last) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ design/cdbr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbr_datapath: ring state, slot memories and result registers
// Holds the configuration, transfer ids, reader bookkeeping, the slot tag and
// length memories, the slot offset multiplier and the modulo unit.
// ----------------------------------------------------------------------------
module cdbr_datapath #(
   parameter int MAX_SLOTS   = 16,
   parameter int NUM_READERS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cdbr_pkg::cmd_type              cmd,
   output cdbr_pkg::status_type           sts,
   input  logic [cdbr_pkg::OP_W-1:0]      req_operation,
   input  logic [cdbr_pkg::LEN_W-1:0]     req_completed_length,
   input  logic [cdbr_pkg::RDR_W-1:0]     req_reader_index,
   input  logic [cdbr_pkg::LEN_W-1:0]     req_requested_bytes,
   input  logic                           csr_write_enable,
   input  logic [cdbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cdbr_pkg::CSR_DAT_W-1:0] csr_write_data,
   output logic                           rsp_valid,
   output logic                           rsp_program_valid,
   output logic [cdbr_pkg::ID_W-1:0]      rsp_program_address,
   output logic [cdbr_pkg::LEN_W-1:0]     rsp_program_length,
   output logic                           rsp_engine_stop,
   output logic                           rsp_notify_readers,
   output logic [cdbr_pkg::ST_W-1:0]      rsp_read_status,
   output logic [cdbr_pkg::OFS_W-1:0]     rsp_read_offset,
   output logic [cdbr_pkg::LEN_W-1:0]     rsp_read_length,
   output logic [cdbr_pkg::ID_W-1:0]      rsp_read_transfer_id
);

   localparam int ID_W   = cdbr_pkg::ID_W;
   localparam int LEN_W  = cdbr_pkg::LEN_W;
   localparam int CNT_W  = cdbr_pkg::CNT_W;
   localparam int CNT_MAX = (MAX_SLOTS > 31) ? 31 : MAX_SLOTS;
   localparam int DEPTH  = CNT_MAX;
   localparam int IW     = $clog2(DEPTH);
   localparam int RW     = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(CNT_MAX);
   localparam logic [CNT_W-1:0] CNT_RESET_V =
      (cdbr_pkg::COUNT_RESET > CNT_MAX_V) ? CNT_MAX_V : cdbr_pkg::COUNT_RESET;

   // latched event
   logic [cdbr_pkg::OP_W-1:0]  op_ff;
   logic [LEN_W-1:0]           clen_ff;
   logic [cdbr_pkg::RDR_W-1:0] rdr_ff;
   logic [LEN_W-1:0]           req_ff;

   // configuration
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [LEN_W-1:0] size_ff;
   logic [ID_W-1:0]  base_ff;

   // ring and reader state
   logic [ID_W-1:0]        ip_ff;
   logic [ID_W-1:0]        lf_ff;
   logic [NUM_READERS-1:0] active_ff;
   logic [ID_W-1:0]        last_read_ff [NUM_READERS];

   // working registers
   logic [ID_W-1:0]             arm_id_ff;
   logic [CNT_W-1:0]            slot_ff;
   logic [cdbr_pkg::PROD_W-1:0] prod_ff;
   logic [ID_W-1:0]             scan_id_ff;
   logic [ID_W-1:0]             lr_ff;
   logic [CNT_W-1:0]            scan_rem_ff;

   // slot memories with per-entry valid bits
   logic [ID_W-1:0]  tag_mem [DEPTH];
   logic [LEN_W-1:0] len_mem [DEPTH];
   logic [DEPTH-1:0] tag_vld_ff;
   logic [DEPTH-1:0] len_vld_ff;
   logic [ID_W-1:0]  tag_q;
   logic [LEN_W-1:0] len_q;
   logic             tag_vld_q;
   logic             len_vld_q;

   // result registers
   logic                          rsp_valid_ff;
   logic                          prog_valid_ff;
   logic [ID_W-1:0]               prog_addr_ff;
   logic [LEN_W-1:0]              prog_len_ff;
   logic                          stop_ff;
   logic                          notify_ff;
   logic [cdbr_pkg::ST_W-1:0]     status_ff;
   logic [cdbr_pkg::OFS_W-1:0]    offset_ff;
   logic [LEN_W-1:0]              rlen_ff;
   logic [ID_W-1:0]               rid_ff;

   // combinational helpers
   logic                   reader_ok;
   logic [NUM_READERS-1:0] bit_mask;
   logic [ID_W-1:0]        lr_sel;
   logic [ID_W-1:0]        lag;
   logic [ID_W-1:0]        count_ext;
   logic                   jump;
   logic [ID_W-1:0]        lr_new;
   logic [CNT_W-1:0]       rem_new;
   logic [ID_W-1:0]        arm_id_in;
   logic [ID_W-1:0]        mod_dividend;
   logic                   mod_done;
   logic [CNT_W-1:0]       mod_rem;
   logic [CNT_W-1:0]       slot_next;
   logic [CNT_W-1:0]       slot_prev;
   logic [IW-1:0]          slot_idx;
   logic [IW-1:0]          prev_idx;
   logic [ID_W-1:0]        tag_eff;
   logic [LEN_W-1:0]       len_eff;
   logic [cdbr_pkg::PROD_W-1:0] prod_in;

   // slot count write with clamping
   always_comb begin
      count_in = csr_write_data[CNT_W-1:0];
      if (count_in < cdbr_pkg::COUNT_MIN) begin
         count_in = cdbr_pkg::COUNT_MIN;
      end else if (count_in > CNT_MAX_V) begin
         count_in = CNT_MAX_V;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET_V;
         size_ff  <= cdbr_pkg::SIZE_RESET;
         base_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            cdbr_pkg::CSR_SLOT_COUNT: count_ff <= count_in;
            cdbr_pkg::CSR_SLOT_SIZE:  size_ff  <= csr_write_data[LEN_W-1:0];
            cdbr_pkg::CSR_RING_BASE:  base_ff  <= csr_write_data[ID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // latch the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         clen_ff <= req_completed_length;
         rdr_ff  <= req_reader_index;
         req_ff  <= req_requested_bytes;
      end
   end

   // reader selection and read distance
   always_comb begin
      reader_ok = (32'(rdr_ff) < 32'(NUM_READERS));
      bit_mask  = reader_ok ? (NUM_READERS'(1) << rdr_ff) : '0;
      lr_sel    = last_read_ff[RW'(rdr_ff)];
      count_ext = ID_W'(count_ff);
      lag       = lf_ff - lr_sel;
      jump      = (lag >= count_ext - 1'b1);
      lr_new    = jump ? (lf_ff - count_ext + 2'd2) : lr_sel;
      rem_new   = jump ? (count_ff - 2'd2) : lag[CNT_W-1:0];
      arm_id_in = (op_ff == cdbr_pkg::OP_COMPLETE) ? (ip_ff + 1'b1) : ip_ff;
      mod_dividend = cmd.mod_from_scan ? (lr_ff + 1'b1) : arm_id_in;
   end

   // slot stepping around the ring
   always_comb begin
      slot_next = (slot_ff == count_ff - 1'b1) ? '0 : (slot_ff + 1'b1);
      slot_prev = (slot_ff == '0) ? (count_ff - 1'b1) : (slot_ff - 1'b1);
      slot_idx  = IW'(slot_ff);
      prev_idx  = IW'(slot_prev);
      tag_eff   = tag_vld_q ? tag_q : '0;
      len_eff   = len_vld_q ? len_q : '0;
      prod_in   = cdbr_pkg::PROD_W'(slot_ff) * cdbr_pkg::PROD_W'(size_ff);
   end

   cdbr_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // transfer ids and reader activity
   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff     <= ID_W'(1);
         lf_ff     <= '0;
         active_ff <= '0;
      end else begin
         if (cmd.arm_write) begin
            ip_ff <= arm_id_ff;
         end
         if (cmd.fin_write) begin
            lf_ff <= ip_ff - 1'b1;
         end
         if (cmd.do_open) begin
            active_ff <= active_ff | bit_mask;
         end else if (cmd.do_close) begin
            active_ff <= active_ff & ~bit_mask;
         end
      end
   end

   // per-reader last read id
   always_ff @(posedge clock) begin
      if (cmd.do_open) begin
         last_read_ff[RW'(rdr_ff)] <= lf_ff;
      end else if (cmd.read_prep && jump) begin
         last_read_ff[RW'(rdr_ff)] <= lr_new;
      end else if (cmd.scan_hit) begin
         last_read_ff[RW'(rdr_ff)] <= scan_id_ff;
      end
   end

   // working registers for arming and scanning
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.arm_load) begin
         arm_id_ff <= arm_id_in;
      end
      if (cmd.slot_from_mod) begin
         slot_ff <= mod_rem;
      end else if (cmd.scan_next) begin
         slot_ff <= slot_next;
      end
      if (cmd.read_prep) begin
         lr_ff       <= lr_new;
         scan_rem_ff <= rem_new;
      end else if (cmd.scan_next) begin
         scan_rem_ff <= scan_rem_ff - 1'b1;
      end
      if (cmd.scan_start) begin
         scan_id_ff <= lr_ff + 1'b1;
      end else if (cmd.scan_next) begin
         scan_id_ff <= scan_id_ff + 1'b1;
      end
   end

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
         len_vld_ff <= '0;
      end else begin
         if (cmd.arm_write) begin
            tag_vld_ff[slot_idx] <= 1'b1;
            len_vld_ff[slot_idx] <= 1'b1;
         end else if (cmd.fin_write) begin
            len_vld_ff[prev_idx] <= 1'b1;
         end
      end
   end

   // slot memories, registered read at the current slot
   always_ff @(posedge clock) begin
      if (cmd.arm_write) begin
         tag_mem[slot_idx] <= arm_id_ff;
         len_mem[slot_idx] <= '0;
      end else if (cmd.fin_write) begin
         len_mem[prev_idx] <= clen_ff;
      end
      tag_q     <= tag_mem[slot_idx];
      len_q     <= len_mem[slot_idx];
      tag_vld_q <= tag_vld_ff[slot_idx];
      len_vld_q <= len_vld_ff[slot_idx];
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   // result fields, cleared when a beat is taken
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         prog_valid_ff <= 1'b0;
         prog_addr_ff  <= '0;
         prog_len_ff   <= '0;
         stop_ff       <= 1'b0;
         notify_ff     <= 1'b0;
         status_ff     <= cdbr_pkg::ST_DATA;
         offset_ff     <= '0;
         rlen_ff       <= '0;
         rid_ff        <= '0;
      end else begin
         if (cmd.arm_out) begin
            prog_valid_ff <= 1'b1;
            prog_addr_ff  <= base_ff + ID_W'(prod_ff);
            prog_len_ff   <= size_ff;
         end
         if (cmd.fin_write) begin
            notify_ff <= 1'b1;
         end
         if (cmd.do_close) begin
            stop_ff <= ((active_ff & bit_mask) != '0) &&
                       ((active_ff & ~bit_mask) == '0);
         end
         if (cmd.set_none || cmd.read_prep) begin
            status_ff <= cdbr_pkg::ST_NONE;
         end else if (cmd.set_nothing) begin
            status_ff <= cdbr_pkg::ST_NOTHING;
         end else if (cmd.scan_hit) begin
            status_ff <= cdbr_pkg::ST_DATA;
            offset_ff <= prod_ff[cdbr_pkg::OFS_W-1:0];
            rlen_ff   <= (req_ff < len_eff) ? req_ff : len_eff;
            rid_ff    <= scan_id_ff;
         end
      end
   end

   // status toward the controller
   always_comb begin
      sts.op         = op_ff;
      sts.engine_on  = (active_ff != '0);
      sts.reader_ok  = reader_ok;
      sts.reader_on  = ((active_ff & bit_mask) != '0);
      sts.ids_equal  = (lf_ff == lr_sel);
      sts.clen_nz    = (clen_ff != '0);
      sts.mod_done   = mod_done;
      sts.scan_empty = (scan_rem_ff == '0);
      sts.scan_last  = (scan_rem_ff == CNT_W'(1));
      sts.scan_match = (tag_eff == scan_id_ff);
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_program_valid    = prog_valid_ff;
   assign rsp_program_address  = prog_addr_ff;
   assign rsp_program_length   = prog_len_ff;
   assign rsp_engine_stop      = stop_ff;
   assign rsp_notify_readers   = notify_ff;
   assign rsp_read_status      = status_ff;
   assign rsp_read_offset      = offset_ff;
   assign rsp_read_length      = rlen_ff;
   assign rsp_read_transfer_id = rid_ff;

endmodule

@@ design/cyclic_dma_buffer_ring_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_dma_buffer_ring_core: manager of a ring of equal dma buffers
// Arms and programs ring slots on completions and errors, tracks readers and
// answers reader reads with the next finished buffer.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; exactly one result
// beat follows, shown for one cycle with rsp_valid high, and it must be taken
// in that cycle since there is no way to hold it off. Close, unknown
// operations, ignored events and reads that find nothing new are answered
// from the decode state. An event that programs the engine waits for the
// slot of the transfer id from a modulo unit that retires two id bits per
// cycle, arms the slot, on a completion with a nonzero length also fills in
// the previous slot's length, and shows the program fields. A read that has
// to scan tries at most slot_count - 2 slots: the same modulo finds the first
// slot, then each slot costs one registered tag memory read and one compare.
// In a two-slot ring a read that finds something new catches up with no slot
// left to try. The next event may be offered in the cycle the result is
// shown. Configuration must be written only while busy is low, which the
// block does not enforce, and must not be changed while an event is in flight.
module cyclic_dma_buffer_ring_core #(
   parameter int MAX_SLOTS   = 16,
   parameter int NUM_READERS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cdbr_pkg::OP_W-1:0]      req_operation,
   input  logic [cdbr_pkg::LEN_W-1:0]     req_completed_length,
   input  logic [cdbr_pkg::RDR_W-1:0]     req_reader_index,
   input  logic [cdbr_pkg::LEN_W-1:0]     req_requested_bytes,
   input  logic                           csr_write_enable,
   input  logic [cdbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cdbr_pkg::CSR_DAT_W-1:0] csr_write_data,
   output logic                           rsp_valid,
   output logic                           rsp_program_valid,
   output logic [cdbr_pkg::ID_W-1:0]      rsp_program_address,
   output logic [cdbr_pkg::LEN_W-1:0]     rsp_program_length,
   output logic                           rsp_engine_stop,
   output logic                           rsp_notify_readers,
   output logic [cdbr_pkg::ST_W-1:0]      rsp_read_status,
   output logic [cdbr_pkg::OFS_W-1:0]     rsp_read_offset,
   output logic [cdbr_pkg::LEN_W-1:0]     rsp_read_length,
   output logic [cdbr_pkg::ID_W-1:0]      rsp_read_transfer_id
);

   cdbr_pkg::cmd_type    cmd;
   cdbr_pkg::status_type sts;

   // event sequencer
   cdbr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // ring state and result registers
   cdbr_datapath #(
      .MAX_SLOTS   (MAX_SLOTS),
      .NUM_READERS (NUM_READERS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_operation),
      .req_completed_length (req_completed_length),
      .req_reader_index     (req_reader_index),
      .req_requested_bytes  (req_requested_bytes),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_program_valid    (rsp_program_valid),
      .rsp_program_address  (rsp_program_address),
      .rsp_program_length   (rsp_program_length),
      .rsp_engine_stop      (rsp_engine_stop),
      .rsp_notify_readers   (rsp_notify_readers),
      .rsp_read_status      (rsp_read_status),
      .rsp_read_offset      (rsp_read_offset),
      .rsp_read_length      (rsp_read_length),
      .rsp_read_transfer_id (rsp_read_transfer_id)
   );

endmodule

@@ design/cdbr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbr_checker: port-level checks of the dma buffer ring core
// Watches the command handshake and result beats at the top level ports.
// ----------------------------------------------------------------------------
module cdbr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic                      rsp_program_valid,
   input logic                      rsp_engine_stop,
   input logic [cdbr_pkg::ST_W-1:0] rsp_read_status
);

   // a taken event keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted event did not raise busy");

   // result beats never come back to back
   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   // the end of an event is marked by its result beat
   a_fall_beat: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   // a result beat is shown only once the event is finished
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while still busy");

   // engine programming comes with the read status at its cleared ST_DATA value and no stop
   a_prog_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_program_valid) |->
         (rsp_read_status == cdbr_pkg::ST_DATA && !rsp_engine_stop))
      else $error("program beat mixed with read or stop fields");

endmodule

bind cyclic_dma_buffer_ring_core cdbr_checker u_cdbr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_program_valid (rsp_program_valid),
   .rsp_engine_stop   (rsp_engine_stop),
   .rsp_read_status   (rsp_read_status)
);
